// File: hw/rtl/tlnf_pkg.sv
// Shared types and constants of the text line numbering filter.
package tlnf_pkg;

  // decimal places of a line number
  localparam int unsigned NUM_DIGITS = 6;
  localparam int unsigned BCD_W      = 4 * NUM_DIGITS;

  // output slots of one job, in emit order
  localparam int unsigned SLOT_NUM_TAB   = NUM_DIGITS;
  localparam int unsigned SLOT_CR_CARET  = NUM_DIGITS + 1;
  localparam int unsigned SLOT_CR_M      = NUM_DIGITS + 2;
  localparam int unsigned SLOT_END_TAB   = NUM_DIGITS + 3;
  localparam int unsigned SLOT_DOLLAR    = NUM_DIGITS + 4;
  localparam int unsigned SLOT_TAB_CARET = NUM_DIGITS + 5;
  localparam int unsigned SLOT_CHAR      = NUM_DIGITS + 6;
  localparam int unsigned SLOTS          = NUM_DIGITS + 7;

  // job queue between front and back
  localparam int unsigned JQ_AW    = 2;
  localparam int unsigned JQ_DEPTH = 1 << JQ_AW;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_I      = 8'd73;
  localparam logic [7:0] CH_M      = 8'd77;
  localparam logic [7:0] CH_CARET  = 8'd94;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUMBER_NONBLANK = 3'd0,
    CFG_SHOW_ENDS       = 3'd1,
    CFG_NUMBER_ALL      = 3'd2,
    CFG_SQUEEZE_BLANK   = 3'd3,
    CFG_SHOW_TABS       = 3'd4,
    CFG_SHOW_CR         = 3'd5
  } cfg_idx_t;

  // one classified input byte: which slots to emit, number snapshot, byte
  typedef struct packed {
    logic [SLOTS-1:0] mask;
    logic [BCD_W-1:0] bcd;
    logic [7:0]       ch;
  } job_t;

endpackage

// File: hw/rtl/text_line_numbering_filter_unit.sv
// Top level of the text line numbering filter.
//
// Input: one text byte per beat on in_byte, taken when push is high and full
// is low. in_file_start resets the line counter and line state before that
// byte. Output: the rewritten stream, one byte per beat; the oldest byte sits
// on out_byte while empty is low and leaves when pop is high. out_last_of_run
// marks the final byte caused by one input byte; a squeezed blank line
// produces nothing.
// Throughput: one output byte per cycle while pop is high, so a plain byte passes at one per
// cycle; a numbered line start emits six digits and a tab before the byte,
// and ^M, $ and ^I add their own bytes. A four-entry job queue absorbs
// these bursts before full rises. An accepted byte passes the job queue,
// the slot register and output register. Configuration is written through
// cfg_we/cfg_index/cfg_wdata; the user must write it only while idle, as
// the block does not enforce this. Reset clears all options, sets the line
// number to one and empties the queue and output register. When pop stays
// low, the output register holds, the queue fills and full stalls the input.
module text_line_numbering_filter_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tlnf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                           cfg_wdata,
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     in_byte,
  input  logic                           in_file_start,
  output logic                           empty,
  input  logic                           pop,
  output logic [7:0]                     out_byte,
  output logic                           out_last_of_run
);

  logic           q_push, q_full, q_pop, q_nonempty;
  tlnf_pkg::job_t q_job, q_head;

  assign full = q_full;

  tlnf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .push          (push),
    .in_byte       (in_byte),
    .in_file_start (in_file_start),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (q_job)
  );

  tlnf_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .head_job (q_head),
    .nonempty (q_nonempty)
  );

  tlnf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_nonempty      (q_nonempty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// File: hw/rtl/tlnf_front.sv
// Front end: configuration registers, line state and byte classification.
module tlnf_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tlnf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                           cfg_wdata,
  input  logic                           push,
  input  logic [7:0]                     in_byte,
  input  logic                           in_file_start,
  input  logic                           q_full,
  output logic                           q_push,
  output tlnf_pkg::job_t                 q_job
);

  logic number_nonblank_r, show_ends_r, number_all_r;
  logic squeeze_blank_r, show_tabs_r, show_cr_r;

  logic [tlnf_pkg::BCD_W-1:0] cnt_r, cnt_nxt, cnt_eff;
  logic                       als_r, als_nxt, als_eff;
  logic [7:0]                 prev_r, prev_nxt, prev_eff;
  logic [1:0]                 br_r, br_nxt, br_eff;

  logic accept, is_nl, is_tab, drop, numbering;
  logic [tlnf_pkg::SLOTS-1:0] mask;

  function automatic logic [tlnf_pkg::BCD_W-1:0] bcd_inc(
    input logic [tlnf_pkg::BCD_W-1:0] v);
    logic [tlnf_pkg::BCD_W-1:0] r;
    logic [4:0] s;
    logic carry, all_nine;
    r = '0;
    carry = 1'b1;
    all_nine = 1'b1;
    for (int i = 0; i < tlnf_pkg::NUM_DIGITS; i++) begin
      if (v[4*i +: 4] != 4'd9) all_nine = 1'b0;
      s = {1'b0, v[4*i +: 4]} + {4'd0, carry};
      if (s >= 5'd10) begin
        r[4*i +: 4] = 4'd0;
        carry = 1'b1;
      end else begin
        r[4*i +: 4] = s[3:0];
        carry = 1'b0;
      end
    end
    return all_nine ? v : r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_nonblank_r <= 1'b0;
      show_ends_r       <= 1'b0;
      number_all_r      <= 1'b0;
      squeeze_blank_r   <= 1'b0;
      show_tabs_r       <= 1'b0;
      show_cr_r         <= 1'b0;
    end else if (cfg_we) begin
      case (tlnf_pkg::cfg_idx_t'(cfg_index))
        tlnf_pkg::CFG_NUMBER_NONBLANK: number_nonblank_r <= cfg_wdata;
        tlnf_pkg::CFG_SHOW_ENDS:       show_ends_r       <= cfg_wdata;
        tlnf_pkg::CFG_NUMBER_ALL:      number_all_r      <= cfg_wdata;
        tlnf_pkg::CFG_SQUEEZE_BLANK:   squeeze_blank_r   <= cfg_wdata;
        tlnf_pkg::CFG_SHOW_TABS:       show_tabs_r       <= cfg_wdata;
        tlnf_pkg::CFG_SHOW_CR:         show_cr_r         <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    accept = push && !q_full;
    // file start resets line state ahead of this byte
    if (in_file_start) begin
      cnt_eff  = tlnf_pkg::BCD_W'(1);
      als_eff  = 1'b1;
      prev_eff = tlnf_pkg::CH_NL;
      br_eff   = 2'd0;
    end else begin
      cnt_eff  = cnt_r;
      als_eff  = als_r;
      prev_eff = prev_r;
      br_eff   = br_r;
    end

    is_nl  = (in_byte == tlnf_pkg::CH_NL);
    is_tab = (in_byte == tlnf_pkg::CH_TAB);

    if (is_nl && prev_eff == tlnf_pkg::CH_NL) begin
      br_nxt = (als_eff && br_eff < 2'd2) ? br_eff + 2'd1 : br_eff;
    end else begin
      br_nxt = 2'd0;
    end
    drop = squeeze_blank_r && (br_nxt > 2'd1);

    numbering = als_eff && (number_nonblank_r ? !is_nl : number_all_r);

    mask = '0;
    for (int i = 0; i <= tlnf_pkg::SLOT_NUM_TAB; i++) mask[i] = numbering;
    mask[tlnf_pkg::SLOT_CR_CARET]  = show_cr_r && is_nl && prev_eff == tlnf_pkg::CH_CR;
    mask[tlnf_pkg::SLOT_CR_M]      = mask[tlnf_pkg::SLOT_CR_CARET];
    mask[tlnf_pkg::SLOT_END_TAB]   = show_ends_r && is_nl && als_eff && number_nonblank_r;
    mask[tlnf_pkg::SLOT_DOLLAR]    = show_ends_r && is_nl;
    mask[tlnf_pkg::SLOT_TAB_CARET] = show_tabs_r && is_tab;
    mask[tlnf_pkg::SLOT_CHAR]      = 1'b1;

    if (drop) begin
      // squeezed line keeps byte history
      cnt_nxt  = cnt_eff;
      als_nxt  = als_eff;
      prev_nxt = prev_eff;
    end else begin
      cnt_nxt  = numbering ? bcd_inc(cnt_eff) : cnt_eff;
      als_nxt  = (show_tabs_r && is_tab) ? 1'b0 : is_nl;
      prev_nxt = in_byte;
    end

    q_push    = accept && !drop;
    q_job.mask = mask;
    q_job.bcd  = cnt_eff;
    q_job.ch   = in_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= tlnf_pkg::BCD_W'(1);
      als_r  <= 1'b1;
      prev_r <= tlnf_pkg::CH_NL;
      br_r   <= 2'd0;
    end else if (accept) begin
      cnt_r  <= cnt_nxt;
      als_r  <= als_nxt;
      prev_r <= prev_nxt;
      br_r   <= br_nxt;
    end
  end

endmodule

// File: hw/rtl/tlnf_jobq.sv
// Short job queue that decouples the classifier from the byte sequencer.
module tlnf_jobq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tlnf_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output tlnf_pkg::job_t head_job,
  output logic           nonempty
);

  tlnf_pkg::job_t               mem_r [tlnf_pkg::JQ_DEPTH];
  logic [tlnf_pkg::JQ_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [tlnf_pkg::JQ_AW:0]     count_r, count_nxt;

  assign full     = (count_r == (tlnf_pkg::JQ_AW+1)'(tlnf_pkg::JQ_DEPTH));
  assign nonempty = (count_r != '0);
  assign head_job = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

// File: hw/rtl/tlnf_back.sv
// Back end: walks the slots of each job and emits one byte per beat.
module tlnf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_nonempty,
  input  tlnf_pkg::job_t q_head,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     out_byte,
  output logic           out_last_of_run
);

  logic [tlnf_pkg::SLOTS-1:0] cur_mask_r, cur_mask_nxt;
  logic [tlnf_pkg::BCD_W-1:0] cur_bcd_r;
  logic [7:0]                 cur_ch_r;
  logic                       cur_tab_r;

  logic       out_valid_r;
  logic [7:0] out_byte_r, byte_sel;
  logic       out_last_r;

  logic busy, out_free, emit, last, load;
  logic [tlnf_pkg::SLOTS-1:0] low, rem;
  logic [7:0] slot_byte [tlnf_pkg::SLOTS];
  logic [3:0] d;
  logic       leading;

  always_comb begin
    // digit bytes, most significant first, blank until the first nonzero
    leading = 1'b1;
    for (int i = 0; i < tlnf_pkg::NUM_DIGITS; i++) begin
      d = cur_bcd_r[4*(tlnf_pkg::NUM_DIGITS-1-i) +: 4];
      if (d != 4'd0 || i == tlnf_pkg::NUM_DIGITS - 1) leading = 1'b0;
      slot_byte[i] = leading ? tlnf_pkg::CH_SPACE : tlnf_pkg::CH_ZERO + {4'd0, d};
    end
    slot_byte[tlnf_pkg::SLOT_NUM_TAB]   = tlnf_pkg::CH_TAB;
    slot_byte[tlnf_pkg::SLOT_CR_CARET]  = tlnf_pkg::CH_CARET;
    slot_byte[tlnf_pkg::SLOT_CR_M]      = tlnf_pkg::CH_M;
    slot_byte[tlnf_pkg::SLOT_END_TAB]   = tlnf_pkg::CH_TAB;
    slot_byte[tlnf_pkg::SLOT_DOLLAR]    = tlnf_pkg::CH_DOLLAR;
    slot_byte[tlnf_pkg::SLOT_TAB_CARET] = tlnf_pkg::CH_CARET;
    // the caret bit is already consumed here, so use the flag taken at load
    slot_byte[tlnf_pkg::SLOT_CHAR]      = cur_tab_r ? tlnf_pkg::CH_I : cur_ch_r;
  end

  always_comb begin
    busy     = (cur_mask_r != '0);
    out_free = !out_valid_r || pop;
    emit     = busy && out_free;
    low      = cur_mask_r & (~cur_mask_r + 1'b1);
    rem      = cur_mask_r & ~low;
    last     = (rem == '0);
    byte_sel = '0;
    for (int i = 0; i < tlnf_pkg::SLOTS; i++) begin
      if (low[i]) byte_sel = slot_byte[i];
    end
    // refill when idle or in the beat that sends the final byte of a job
    load  = !busy || (emit && last);
    q_pop = load && q_nonempty;
    if (q_pop) begin
      cur_mask_nxt = q_head.mask;
    end else if (emit) begin
      cur_mask_nxt = rem;
    end else begin
      cur_mask_nxt = cur_mask_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_mask_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_mask_r <= cur_mask_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_bcd_r <= q_head.bcd;
      cur_ch_r  <= q_head.ch;
      cur_tab_r <= q_head.mask[tlnf_pkg::SLOT_TAB_CARET];
    end
    if (emit) begin
      out_byte_r <= byte_sel;
      out_last_r <= last;
    end
  end

  assign empty           = !out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

endmodule

// File: verif/text_line_numbering_filter_unit_test.sv
// Self-checking testbench for the text line numbering filter top level.
module text_line_numbering_filter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned IDLE_PCT     = 9;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_BYTES  = 26;
  localparam int unsigned CARRY_LINES  = 30;
  localparam int unsigned PRINT_CAP    = 25;

  // indexes past the register list; writes there must change nothing
  localparam logic [tlnf_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [tlnf_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_beat_t;

  logic                           clk           = 1'b0;
  logic                           rst_n         = 1'b0;
  logic                           cfg_we        = 1'b0;
  logic [tlnf_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
  logic                           cfg_wdata     = 1'b0;
  logic                           push          = 1'b0;
  logic [7:0]                     in_byte       = '0;
  logic                           in_file_start = 1'b0;
  logic                           pop           = 1'b0;
  logic                           full;
  logic                           empty;
  logic [7:0]                     out_byte;
  logic                           out_last_of_run;

  text_beat_t                 expected_text[$];
  logic [5:0]                 opts;
  logic [tlnf_pkg::BCD_W-1:0] line_no_bcd;
  logic                       line_fresh;
  logic [7:0]                 last_char;
  logic [1:0]                 empty_run;

  bit calm = 1'b0;
  int errors;
  int bytes_sent;
  int beats_seen;
  int numbered_lines;
  int settings_used;
  int cycles;

  text_line_numbering_filter_unit dut (.*);

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= PRINT_CAP) $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  // compare each popped beat with the oldest predicted one
  always @(posedge clk) begin
    text_beat_t want;
    if (rst_n && pop && !empty) begin
      beats_seen++;
      if (expected_text.size() == 0) begin
        report_mismatch($sformatf("unexpected beat 0x%02h", out_byte));
      end else begin
        want = expected_text.pop_front();
        if (out_byte !== want.ch)
          report_mismatch($sformatf("byte 0x%02h, want 0x%02h", out_byte, want.ch));
        if (out_last_of_run !== want.last)
          report_mismatch($sformatf("last_of_run %b, want %b", out_last_of_run, want.last));
      end
    end
    pop <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  function automatic void reset_lines();
    line_no_bcd = 1;
    line_fresh  = 1'b1;
    last_char   = tlnf_pkg::CH_NL;
    empty_run   = '0;
  endfunction

  // rewrite one accepted byte into the beats the filter must emit
  function automatic void rewrite_byte(input logic [7:0] ch, input logic fs);
    logic [7:0]                 bytes[$];
    logic [3:0]                 d;
    logic [tlnf_pkg::BCD_W-1:0] nxt;
    bit                         leading;
    bit                         all_nines;
    bit                         carry;
    if (fs) reset_lines();
    if (ch == tlnf_pkg::CH_NL && last_char == tlnf_pkg::CH_NL) begin
      if (line_fresh && empty_run < 2) empty_run++;
    end else begin
      empty_run = '0;
    end
    // drop a squeezed blank line whole, state untouched
    if (opts[tlnf_pkg::CFG_SQUEEZE_BLANK] && empty_run > 1) return;
    if (line_fresh && (opts[tlnf_pkg::CFG_NUMBER_NONBLANK] ? (ch != tlnf_pkg::CH_NL)
                                                           : opts[tlnf_pkg::CFG_NUMBER_ALL]))
    begin
      leading = 1'b1;
      for (int i = tlnf_pkg::NUM_DIGITS - 1; i >= 0; i--) begin
        d = line_no_bcd[4*i +: 4];
        if (d != 0 || i == 0) leading = 1'b0;
        bytes.push_back(leading ? tlnf_pkg::CH_SPACE : 8'(tlnf_pkg::CH_ZERO + d));
      end
      bytes.push_back(tlnf_pkg::CH_TAB);
      all_nines = 1'b1;
      carry     = 1'b1;
      nxt       = '0;
      for (int i = 0; i < tlnf_pkg::NUM_DIGITS; i++) begin
        d = line_no_bcd[4*i +: 4];
        if (d != 9) all_nines = 1'b0;
        if (carry && d == 9) begin
          nxt[4*i +: 4] = '0;
        end else begin
          nxt[4*i +: 4] = d + carry;
          carry = 1'b0;
        end
      end
      // hold at all nines
      if (!all_nines) line_no_bcd = nxt;
      numbered_lines++;
    end
    if (opts[tlnf_pkg::CFG_SHOW_CR] && ch == tlnf_pkg::CH_NL && last_char == tlnf_pkg::CH_CR)
    begin
      bytes.push_back(tlnf_pkg::CH_CARET);
      bytes.push_back(tlnf_pkg::CH_M);
    end
    if (opts[tlnf_pkg::CFG_SHOW_ENDS] && ch == tlnf_pkg::CH_NL) begin
      if (line_fresh && opts[tlnf_pkg::CFG_NUMBER_NONBLANK]) bytes.push_back(tlnf_pkg::CH_TAB);
      bytes.push_back(tlnf_pkg::CH_DOLLAR);
    end
    if (opts[tlnf_pkg::CFG_SHOW_TABS] && ch == tlnf_pkg::CH_TAB) begin
      bytes.push_back(tlnf_pkg::CH_CARET);
      bytes.push_back(tlnf_pkg::CH_I);
      line_fresh = 1'b0;
    end else begin
      bytes.push_back(ch);
      line_fresh = (ch == tlnf_pkg::CH_NL);
    end
    last_char = ch;
    foreach (bytes[i]) expected_text.push_back('{bytes[i], i == bytes.size() - 1});
  endfunction

  function automatic logic [5:0] options(input bit nonblank, ends, all, squeeze, tabs, cr);
    logic [5:0] m;
    m = '0;
    m[tlnf_pkg::CFG_NUMBER_NONBLANK] = nonblank;
    m[tlnf_pkg::CFG_SHOW_ENDS]       = ends;
    m[tlnf_pkg::CFG_NUMBER_ALL]      = all;
    m[tlnf_pkg::CFG_SQUEEZE_BLANK]   = squeeze;
    m[tlnf_pkg::CFG_SHOW_TABS]       = tabs;
    m[tlnf_pkg::CFG_SHOW_CR]         = cr;
    return m;
  endfunction

  // hold push high from the accept edge if the next byte follows at once
  task automatic send_byte(input logic [7:0] b, input logic fs);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push          <= 1'b1;
    in_byte       <= b;
    in_file_start <= fs;
    @(posedge clk);
    while (full) @(posedge clk);
    rewrite_byte(b, fs);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_byte(s[i], 1'b0);
  endtask

  // drain all predicted beats, then idle for DRAIN_CYCLES so any extra beat is flagged
  task automatic settle();
    push <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_options(input logic [5:0] want);
    tlnf_pkg::cfg_idx_t idx;
    idx = idx.first();
    repeat (idx.num()) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= want[idx];
      @(posedge clk);
      opts[idx] = want[idx];
      idx = idx.next();
    end
    cfg_index <= CFG_SPARE_A;
    cfg_wdata <= 1'b1;
    @(posedge clk);
    cfg_index <= CFG_SPARE_B;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [7:0] pick_text_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 18) return tlnf_pkg::CH_NL;
    if (r < 25) return tlnf_pkg::CH_CR;
    if (r < 33) return tlnf_pkg::CH_TAB;
    if (r < 43) return 8'($urandom_range(255));
    return 8'($urandom_range(126, 32));
  endfunction

  task automatic test_plain_pass();
    set_options(options(0, 0, 0, 0, 0, 0));
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("a\tb\r\n");
    settle();
  endtask

  task automatic test_number_every_line();
    set_options(options(0, 1, 1, 0, 0, 0));
    send_text("x\n\ny");
    // restart the count in the middle of a line
    send_byte("z", 1'b1);
    settle();
  endtask

  task automatic test_nonblank_overrides();
    set_options(options(1, 1, 1, 0, 0, 0));
    send_text("\nq\n");
    settle();
  endtask

  task automatic test_squeeze_and_marks();
    set_options(options(0, 1, 1, 1, 1, 1));
    send_text("\n\n\n\r\n\t\n");
    settle();
  endtask

  // walk the line number through several decimal carries
  task automatic test_number_carry();
    set_options(options(0, 0, 1, 0, 0, 0));
    calm = 1'b1;
    repeat (CARRY_LINES) send_byte(tlnf_pkg::CH_NL, 1'b0);
    calm = 1'b0;
    settle();
  endtask

  task automatic test_random_text();
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) set_options('1);
      else if (p == 1) set_options('0);
      else set_options(6'($urandom));
      calm = (p == 2);
      repeat (PHASE_BYTES) send_byte(pick_text_byte(), $urandom_range(99) < 3);
      calm = 1'b0;
      settle();
    end
  endtask

  initial begin
    opts = '0;
    reset_lines();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_plain_pass();
    test_number_every_line();
    test_nonblank_overrides();
    test_squeeze_and_marks();
    test_number_carry();
    test_random_text();
    $display("covered %0d input bytes, %0d output beats, %0d numbered lines",
             bytes_sent, beats_seen, numbered_lines);
    $display("under %0d option settings, %0d mismatches", settings_used, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
